@@ hw/rtl/kwlm_pkg.sv @@
// Shared types and constants for the K-weighted loudness meter.
// Depends on nothing.
package kwlm_pkg;

    localparam int AccBits  = 72;
    localparam int LoudFloor = -17920;
    localparam int LoudCeil  = 2560;
    localparam logic [25:0] TenLog2Q24 = 26'd50504453;

    typedef logic signed [33:0] coef_t;

    // high-pass b0 b1 b2 a1 a2, then high shelf
    localparam coef_t HpCoef [5] = '{
        34'sd1073741824, -34'sd2147483648, 34'sd1073741824,
        -34'sd2136797184, 34'sd1063081984};
    localparam coef_t ShCoef [5] = '{
        34'sd1648327767, -34'sd2890186776, 34'sd1286764483,
        -34'sd1815331593, 34'sd786495243};

    typedef enum logic [3:0] {
        ST_IDLE, ST_FILT, ST_SQ, ST_RING, ST_WIN,
        ST_DIV, ST_LOG, ST_NEXT, ST_OUT
    } state_t;

endpackage

@@ hw/rtl/kwlm_if.sv @@
// Valid/ready stream interface carrying one payload.
// Depends on nothing.
interface kwlm_if #(parameter int W = 8);
    logic valid;
    logic ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/k_weighted_loudness_meter.sv @@
// Top level of the K-weighted loudness meter: filter, rings, mean, log sequencer.
// Depends on kwlm_pkg, kwlm_if, kwlm_mac, kwlm_div.
// Per sample: ten serial multiplies for the two biquads, one square, then per
// window a division and 16 squarings for the log.
// One sample at a time: a request is accepted only in idle, once the last result is loaded for output.
// Reset clears filter state, sums, fills and counts; the ring stores hold no reset.
module k_weighted_loudness_meter
    import kwlm_pkg::*;
#(
    parameter int MOMENTARY_LEN = 19200,
    parameter int SHORT_LEN     = 144000,
    parameter int SAMPLE_BITS   = 24
)(
    input  logic clk,
    input  logic rst_n,
    kwlm_if.sink   in_req,
    kwlm_if.source out_res
);
    localparam int MW = (MOMENTARY_LEN > 1) ? $clog2(MOMENTARY_LEN) : 1;
    localparam int SW = (SHORT_LEN > 1) ? $clog2(SHORT_LEN) : 1;
    localparam int MC = $clog2(MOMENTARY_LEN + 1);
    localparam int SC = $clog2(SHORT_LEN + 1);

    logic [31:0] mstore [MOMENTARY_LEN];
    logic [31:0] sstore [SHORT_LEN];
    logic [31:0] mrd_reg, srd_reg;

    state_t state_reg, state_next;

    logic signed [31:0] x_reg, xd1_reg, xd2_reg, hd1_reg, hd2_reg, kd1_reg, kd2_reg;
    logic signed [31:0] h_reg, k_reg;
    logic signed [AccBits-1:0] acc_reg;
    logic [3:0] term_reg;
    logic [31:0] sq_reg;
    logic [63:0] msum_reg, ssum_reg, tsum_reg;
    logic [MC-1:0] mfill_reg;
    logic [SC-1:0] sfill_reg;
    logic [MW-1:0] mpos_reg;
    logic [SW-1:0] spos_reg;
    logic [39:0] tcnt_reg;
    logic [1:0] win_reg;
    logic [63:0] mean_reg;
    logic [5:0] e_reg;
    logic [32:0] lx_reg;
    logic [15:0] frac_reg;
    logic [4:0] it_reg;
    logic [1:0] lph_reg;
    logic [15:0] res_reg [3];
    logic [47:0] out_data_reg;
    logic out_valid_reg;
    logic mac_busy_reg, div_busy_reg;

    logic mac_start, mac_done, div_start, div_done;
    logic signed [33:0] mac_a, mac_b;
    logic signed [67:0] mac_p;
    logic [63:0] div_num, div_quo;
    logic [39:0] div_den;

    kwlm_mac u_mac (.clk, .rst_n, .start(mac_start), .a(mac_a), .b(mac_b),
        .done(mac_done), .prod(mac_p));
    kwlm_div u_div (.clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_quo));

    logic [SAMPLE_BITS-1:0] raw;
    logic signed [31:0] x_in;
    assign raw = in_req.data[SAMPLE_BITS:1];
    always_comb
    begin
        if (SAMPLE_BITS >= 24)
            x_in = 32'(signed'(raw) >>> (SAMPLE_BITS - 24));
        else
            x_in = 32'(signed'(raw)) <<< (24 - SAMPLE_BITS);
    end

    // operand selection for the shared multiplier
    logic shelf;
    logic [2:0] tix;
    assign shelf = term_reg[3];
    assign tix = term_reg[2:0];
    always_comb
    begin
        mac_a = shelf ? ShCoef[tix] : HpCoef[tix];
        unique case (tix)
            3'd0:    mac_b = shelf ? 34'(h_reg) : 34'(x_reg);
            3'd1:    mac_b = shelf ? 34'(hd1_reg) : 34'(xd1_reg);
            3'd2:    mac_b = shelf ? 34'(hd2_reg) : 34'(xd2_reg);
            3'd3:    mac_b = shelf ? 34'(kd1_reg) : 34'(hd1_reg);
            default: mac_b = shelf ? 34'(kd2_reg) : 34'(hd2_reg);
        endcase
        if (state_reg == ST_SQ)
        begin
            mac_a = 34'(k_reg);
            mac_b = 34'(k_reg);
        end
        if (state_reg == ST_LOG)
        begin
            mac_a = signed'({1'b0, lx_reg});
            mac_b = signed'({1'b0, lx_reg});
        end
    end

    logic signed [AccBits-1:0] term_v, acc_sum, acc_fin;
    logic signed [31:0] bq_out;
    assign term_v = AccBits'(mac_p >>> 3);
    assign acc_sum = (tix >= 3'd3) ? acc_reg - term_v : acc_reg + term_v;
    assign acc_fin = (acc_sum + (AccBits'(1) <<< 26)) >>> 27;
    always_comb
    begin
        if (acc_fin > AccBits'(32'sh7fffffff))
            bq_out = 32'sh7fffffff;
        else if (acc_fin < -AccBits'(64'sh80000000))
            bq_out = 32'sh80000000;
        else
            bq_out = acc_fin[31:0];
    end

    logic [67:0] sq_full;
    assign sq_full = (68'(unsigned'(mac_p)) + 68'h20000) >> 18;

    logic mfull, sfull;
    assign mfull = (mfill_reg == MC'(MOMENTARY_LEN));
    assign sfull = (sfill_reg == SC'(SHORT_LEN));

    // 10*log10(2) scaling of log2 value
    logic signed [23:0] dval;
    logic signed [50:0] dprod;
    logic signed [50:0] rnd;
    logic signed [15:0] loud;
    assign dval = 24'(signed'({1'b0, e_reg, frac_reg})) - 24'sd1835008;
    assign dprod = 51'(dval) * 51'(signed'({1'b0, TenLog2Q24}));
    assign rnd = (dprod + (51'sd1 <<< 31)) >>> 32;
    always_comb
    begin
        if (mean_reg == '0 || rnd < 51'(LoudFloor))
            loud = 16'(LoudFloor);
        else if (rnd > 51'(LoudCeil))
            loud = 16'(LoudCeil);
        else
            loud = rnd[15:0];
    end

    logic [67:0] lsq;
    assign lsq = 68'(unsigned'(mac_p)) >> 31;

    logic [5:0] e_norm;
    always_comb
    begin
        e_norm = '0;
        for (int i = 0; i < 64; i++)
            if (mean_reg[i]) e_norm = 6'(i);
    end

    assign in_req.ready = (state_reg == ST_IDLE);
    assign out_res.valid = out_valid_reg;
    assign out_res.data = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_req.valid) state_next = ST_FILT;
            ST_FILT: if (mac_done && term_reg == 4'd12) state_next = ST_SQ;
            ST_SQ:   if (mac_done) state_next = ST_RING;
            ST_RING: state_next = ST_WIN;
            ST_WIN:  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_LOG;
            ST_LOG:  if (lph_reg == 2'd2) state_next = ST_NEXT;
            ST_NEXT: state_next = (win_reg == 2'd2) ? ST_OUT : ST_WIN;
            ST_OUT:  if (!out_valid_reg || out_res.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        mac_start = 1'b0;
        div_start = 1'b0;
        if ((state_reg == ST_FILT || state_reg == ST_SQ) && !mac_busy_reg)
            mac_start = 1'b1;
        if (state_reg == ST_LOG && lph_reg == 2'd1 && !mac_busy_reg)
            mac_start = 1'b1;
        if (state_reg == ST_DIV && !div_busy_reg)
            div_start = 1'b1;
        unique case (win_reg)
            2'd0:    begin div_num = msum_reg; div_den = 40'(mfill_reg); end
            2'd1:    begin div_num = ssum_reg; div_den = 40'(sfill_reg); end
            default: begin div_num = tsum_reg; div_den = tcnt_reg; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mac_busy_reg <= 1'b0;
            div_busy_reg <= 1'b0;
            xd1_reg <= '0; xd2_reg <= '0; hd1_reg <= '0; hd2_reg <= '0;
            kd1_reg <= '0; kd2_reg <= '0;
            msum_reg <= '0; ssum_reg <= '0; tsum_reg <= '0; tcnt_reg <= '0;
            mfill_reg <= '0; sfill_reg <= '0; mpos_reg <= '0; spos_reg <= '0;
            term_reg <= '0; win_reg <= '0; lph_reg <= '0; it_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            // load the next result when no result waits or the waiting one leaves
            if (state_reg == ST_OUT && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_res.ready)
                out_valid_reg <= 1'b0;
            if (mac_start) mac_busy_reg <= 1'b1;
            else if (mac_done) mac_busy_reg <= 1'b0;
            if (div_start) div_busy_reg <= 1'b1;
            else if (div_done) div_busy_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (in_req.valid)
                    begin
                        term_reg <= '0;
                        if (in_req.data[0])
                        begin
                            xd1_reg <= '0; xd2_reg <= '0; hd1_reg <= '0; hd2_reg <= '0;
                            kd1_reg <= '0; kd2_reg <= '0;
                            msum_reg <= '0; ssum_reg <= '0; tsum_reg <= '0;
                            tcnt_reg <= '0; mfill_reg <= '0; sfill_reg <= '0;
                            mpos_reg <= '0; spos_reg <= '0;
                        end
                    end
                ST_FILT:
                    if (mac_done)
                    begin
                        if (term_reg == 4'd4)
                            term_reg <= 4'd8;
                        else
                            term_reg <= term_reg + 4'd1;
                        if (term_reg == 4'd12)
                        begin
                            xd2_reg <= xd1_reg; xd1_reg <= x_reg;
                            hd2_reg <= hd1_reg; hd1_reg <= h_reg;
                            kd2_reg <= kd1_reg; kd1_reg <= bq_out;
                        end
                    end
                ST_RING:
                begin
                    // drop oldest entry once full, else append
                    if (!mfull)
                    begin
                        msum_reg <= msum_reg + 64'(sq_reg);
                        mfill_reg <= mfill_reg + MC'(1);
                    end
                    else
                    begin
                        msum_reg <= msum_reg - 64'(mrd_reg) + 64'(sq_reg);
                        mpos_reg <= (mpos_reg == MW'(MOMENTARY_LEN - 1)) ? '0
                                    : mpos_reg + MW'(1);
                    end
                    if (!sfull)
                    begin
                        ssum_reg <= ssum_reg + 64'(sq_reg);
                        sfill_reg <= sfill_reg + SC'(1);
                    end
                    else
                    begin
                        ssum_reg <= ssum_reg - 64'(srd_reg) + 64'(sq_reg);
                        spos_reg <= (spos_reg == SW'(SHORT_LEN - 1)) ? '0
                                    : spos_reg + SW'(1);
                    end
                    if (tsum_reg > ~64'(sq_reg))
                        tsum_reg <= '1;
                    else
                        tsum_reg <= tsum_reg + 64'(sq_reg);
                    if (tcnt_reg != '1)
                        tcnt_reg <= tcnt_reg + 40'd1;
                    win_reg <= '0;
                end
                ST_DIV: lph_reg <= '0;
                ST_LOG:
                    if (lph_reg == 2'd0)
                        lph_reg <= 2'd1;
                    else if (lph_reg == 2'd1 && mac_done)
                    begin
                        if (it_reg == 5'd15)
                            lph_reg <= 2'd2;
                        it_reg <= it_reg + 5'd1;
                    end
                ST_NEXT:
                begin
                    win_reg <= win_reg + 2'd1;
                    lph_reg <= '0;
                end
                default: ;
            endcase
            if (state_reg == ST_DIV)
                it_reg <= '0;
        end
    end

    // datapath registers; normalize with a combinational leading-one scan
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
            x_reg <= x_in;
        if (state_reg == ST_FILT)
        begin
            if (mac_start && (term_reg == 4'd0 || term_reg == 4'd8))
                acc_reg <= '0;
            if (mac_done)
            begin
                acc_reg <= (term_reg == 4'd4 || term_reg == 4'd12) ? '0 : acc_sum;
                if (term_reg == 4'd4) h_reg <= bq_out;
                if (term_reg == 4'd12) k_reg <= bq_out;
            end
        end
        if (state_reg == ST_SQ && mac_done)
            sq_reg <= (sq_full > 68'hffffffff) ? '1 : sq_full[31:0];
        if (state_reg == ST_RING)
        begin
            if (!mfull) mstore[mfill_reg[MW-1:0]] <= sq_reg;
            else mstore[mpos_reg] <= sq_reg;
            if (!sfull) sstore[sfill_reg[SW-1:0]] <= sq_reg;
            else sstore[spos_reg] <= sq_reg;
        end
        if (state_reg == ST_SQ)
        begin
            mrd_reg <= mstore[mpos_reg];
            srd_reg <= sstore[spos_reg];
        end
        if (state_reg == ST_DIV && div_done)
        begin
            mean_reg <= div_quo;
            e_reg <= '0;
        end
        if (state_reg == ST_LOG)
        begin
            if (lph_reg == 2'd0)
            begin
                e_reg <= e_norm;
                frac_reg <= '0;
            end
            if (lph_reg == 2'd1 && mac_done)
            begin
                frac_reg <= {frac_reg[14:0], lsq[32]};
                lx_reg <= lsq[32] ? lsq[33:1] : lsq[32:0];
            end
        end
        if (state_reg == ST_LOG && lph_reg == 2'd0)
            lx_reg <= (e_norm >= 6'd31) ? 33'(mean_reg >> (e_norm - 6'd31))
                      : 33'(mean_reg << (6'd31 - e_norm));
        if (state_reg == ST_NEXT)
            res_reg[win_reg] <= loud;
        if (state_reg == ST_OUT && state_next == ST_IDLE)
            out_data_reg <= {res_reg[0], res_reg[1], res_reg[2]};
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_req.valid && in_req.ready |=> !in_req.ready)
        else $error("accepted a second request while busy");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mac_busy_reg && div_busy_reg))
        else $error("multiplier and divider active together");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RING |=> tcnt_reg != '0)
        else $error("integrated count did not advance");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.data))
        else $error("waiting result changed before it was taken");
endmodule

@@ hw/rtl/kwlm_mac.sv @@
// Bit-serial signed multiply: one multiplier bit per cycle.
// Depends on kwlm_pkg.
module kwlm_mac
    import kwlm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic signed [33:0] a,
    input  logic signed [33:0] b,
    output logic done,
    output logic signed [67:0] prod
);
    logic signed [67:0] acc_reg, acc_next;
    logic signed [67:0] mc_reg, mc_next;
    logic [33:0] mp_reg, mp_next;
    logic [5:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mc_next   = 68'(a);
            mp_next   = b;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of a two's complement multiplier has negative weight
            if (mp_reg[0])
                acc_next = (cnt_reg == 6'd33) ? acc_reg - mc_reg : acc_reg + mc_reg;
            mc_next  = mc_reg <<< 1;
            mp_next  = mp_reg >> 1;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd33)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign prod = acc_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end
endmodule

@@ hw/rtl/kwlm_div.sv @@
// Restoring divider, one quotient bit per cycle: 64-bit by 40-bit.
// Depends on kwlm_pkg.
module kwlm_div
    import kwlm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [63:0] num,
    input  logic [39:0] den,
    output logic done,
    output logic [63:0] quo
);
    logic [63:0] q_reg, q_next;
    logic [40:0] r_reg, r_next;
    logic [40:0] trial;
    logic [6:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = 1'b0;
        trial     = {r_reg[39:0], q_reg[63]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                r_next = trial - {1'b0, den};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quo = q_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end
endmodule

@@ bench/kwlm_loudness_tb_types.sv @@
`timescale 1ns / 1ps
// Request record and stream widths for the loudness meter bench.
// Depends on nothing.
package kwlm_loudness_tb_types;

    localparam int ReqBits = 25;    // {sample, restart}
    localparam int ResBits = 48;    // {momentary, short window, integrated}

    typedef struct {
        logic signed [23:0] sample;
        logic               restart;
        logic               drain_first;
    } audio_req_t;

    typedef struct {
        logic signed [15:0] momentary;
        logic signed [15:0] short_win;
        logic signed [15:0] integrated;
    } loudness_t;

endpackage

@@ bench/k_weighted_loudness_meter_tb.sv @@
`timescale 1ns / 1ps
// Bench for k_weighted_loudness_meter: random and directed audio requests,
// per-sample loudness predicted in place and checked in order.
// Depends on kwlm_pkg, kwlm_if, kwlm_loudness_tb_types and the block itself.
module k_weighted_loudness_meter_tb
    import kwlm_pkg::*;
    import kwlm_loudness_tb_types::*;
();

    localparam int MomLen   = 19200;
    localparam int ShortLen = 144000;
    localparam int QuietTail = 150;

    logic clk;
    logic rst_n;

    kwlm_if #(.W(ReqBits)) in_req ();
    kwlm_if #(.W(ResBits)) out_res ();

    k_weighted_loudness_meter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_req  (in_req.sink),
        .out_res (out_res.source)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    audio_req_t pending_reqs[$];
    loudness_t  expected_loudness[$];
    int         error_count;
    int         accepted_count;
    int         total_reqs;
    bit         quiet;

    // predictor state
    longint          hp_x1, hp_x2, hp_y1, hp_y2, sh_y1, sh_y2;
    int unsigned     mom_store [MomLen];
    int unsigned     short_store [ShortLen];
    longint unsigned mom_sum, short_sum, total_sum, total_count;
    int              mom_fill, mom_pos, short_fill, short_pos;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want,
                 accepted_count);
        error_count++;
    endtask

    function automatic longint biquad_step(input coef_t c [5], input longint x0,
                                           input longint x1, input longint x2,
                                           input longint y1, input longint y2);
        longint acc;
        acc = ((longint'(c[0]) * x0) >>> 3) + ((longint'(c[1]) * x1) >>> 3)
            + ((longint'(c[2]) * x2) >>> 3) - ((longint'(c[3]) * y1) >>> 3)
            - ((longint'(c[4]) * y2) >>> 3);
        acc = (acc + (longint'(1) << 26)) >>> 27;
        if (acc > 64'sd2147483647)
            acc = 64'sd2147483647;
        if (acc < -64'sd2147483648)
            acc = -64'sd2147483648;
        return acc;
    endfunction

    function automatic logic signed [15:0] db_of_mean(input longint unsigned m);
        int              e;
        longint unsigned x;
        longint unsigned frac;
        longint          d;
        longint          r;
        if (m == 0)
            return 16'(LoudFloor);
        e = 0;
        while (e < 63 && (m >> (e + 1)) != 0)
            e++;
        x = (e >= 31) ? (m >> (e - 31)) : (m << (31 - e));
        frac = 0;
        for (int i = 0; i < 16; i++)
        begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= (64'd1 << 32))
            begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        d = longint'(e) * 65536 + longint'(frac) - 28 * 65536;
        r = (d * longint'(TenLog2Q24) + (longint'(1) << 31)) >>> 32;
        if (r < LoudFloor)
            r = LoudFloor;
        if (r > LoudCeil)
            r = LoudCeil;
        return 16'(r);
    endfunction

    function automatic loudness_t predict_loudness(input audio_req_t req);
        longint          x, h, k;
        longint unsigned mag, sq64;
        int unsigned     sq;
        loudness_t       res;
        if (req.restart)
        begin
            hp_x1 = 0; hp_x2 = 0; hp_y1 = 0; hp_y2 = 0; sh_y1 = 0; sh_y2 = 0;
            mom_sum = 0; mom_fill = 0; mom_pos = 0;
            short_sum = 0; short_fill = 0; short_pos = 0;
            total_sum = 0; total_count = 0;
        end
        x = longint'(req.sample);
        h = biquad_step(HpCoef, x, hp_x1, hp_x2, hp_y1, hp_y2);
        k = biquad_step(ShCoef, h, hp_y1, hp_y2, sh_y1, sh_y2);
        hp_x2 = hp_x1; hp_x1 = x;
        hp_y2 = hp_y1; hp_y1 = h;
        sh_y2 = sh_y1; sh_y1 = k;
        mag = (k < 0) ? longint'(-k) : k;
        sq64 = (mag * mag + (64'd1 << 17)) >> 18;
        sq = (sq64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sq64[31:0];

        if (mom_fill < MomLen)
        begin
            mom_store[mom_fill] = sq;
            mom_sum += sq;
            mom_fill++;
        end
        else
        begin
            if (mom_pos >= MomLen)
                mom_pos = 0;
            mom_sum = mom_sum - mom_store[mom_pos] + sq;
            mom_store[mom_pos] = sq;
            mom_pos = (mom_pos + 1 >= MomLen) ? 0 : mom_pos + 1;
        end
        res.momentary = db_of_mean(mom_sum / longint'(mom_fill));

        if (short_fill < ShortLen)
        begin
            short_store[short_fill] = sq;
            short_sum += sq;
            short_fill++;
        end
        else
        begin
            if (short_pos >= ShortLen)
                short_pos = 0;
            short_sum = short_sum - short_store[short_pos] + sq;
            short_store[short_pos] = sq;
            short_pos = (short_pos + 1 >= ShortLen) ? 0 : short_pos + 1;
        end
        res.short_win = db_of_mean(short_sum / longint'(short_fill));

        // hold both integrated totals at their ceilings
        if (total_sum > 64'hFFFF_FFFF_FFFF_FFFF - sq)
            total_sum = 64'hFFFF_FFFF_FFFF_FFFF;
        else
            total_sum += sq;
        if (total_count < (64'd1 << 40) - 1)
            total_count++;
        res.integrated = db_of_mean(total_sum / total_count);
        return res;
    endfunction

    // request driver
    int         src_gap;
    audio_req_t cur_req;
    always @(posedge clk or negedge rst_n)
    begin
        logic       next_valid;
        audio_req_t nxt;
        if (!rst_n)
        begin
            in_req.valid <= 1'b0;
            in_req.data  <= '0;
            src_gap = 0;
        end
        else
        begin
            next_valid = in_req.valid;
            if (in_req.valid && in_req.ready)
            begin
                expected_loudness.push_back(predict_loudness(cur_req));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (!quiet && $urandom_range(0, 7) == 0)
                    src_gap = $urandom_range(1, 16);
                else if (pending_reqs.size() > 0 &&
                         (!pending_reqs[0].drain_first || expected_loudness.size() == 0))
                begin
                    nxt = pending_reqs.pop_front();
                    cur_req = nxt;
                    in_req.data <= {nxt.sample, nxt.restart};
                    next_valid = 1'b1;
                end
            end
            in_req.valid <= next_valid;
        end
    end

    // result monitor and sink stalls
    int snk_gap;
    always @(posedge clk or negedge rst_n)
    begin
        loudness_t want;
        logic signed [15:0] got_m, got_s, got_i;
        if (!rst_n)
        begin
            out_res.ready <= 1'b0;
            snk_gap = 0;
        end
        else
        begin
            if (out_res.valid && out_res.ready)
            begin
                {got_m, got_s, got_i} = out_res.data;
                if (expected_loudness.size() == 0)
                    report("unexpected result", 0, 0);
                else
                begin
                    want = expected_loudness.pop_front();
                    if (got_m !== want.momentary)
                        report("momentary", got_m, want.momentary);
                    if (got_s !== want.short_win)
                        report("short window", got_s, want.short_win);
                    if (got_i !== want.integrated)
                        report("integrated", got_i, want.integrated);
                end
                accepted_count++;
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                out_res.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                snk_gap = $urandom_range(1, 16);
                out_res.ready <= 1'b0;
            end
            else
                out_res.ready <= 1'b1;
        end
    end

    task automatic queue_req(input int s, input bit rs, input bit drain);
        audio_req_t r;
        r.sample = s[23:0];
        r.restart = rs;
        r.drain_first = drain;
        pending_reqs.push_back(r);
        total_reqs++;
    endtask

    function automatic int random_sample();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 8388607 : -8388608;
            1: return int'($urandom_range(0, 4000)) - 2000;
            2: return int'($urandom_range(0, 200000)) - 100000;
            default: return int'($urandom) >>> 8;
        endcase
    endfunction

    initial
    begin
        error_count = 0;
        accepted_count = 0;
        total_reqs = 0;
        quiet = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // silence, extremes, alternating full scale to push the ceiling and clamps
        queue_req(0, 0, 0);
        queue_req(8388607, 0, 0);
        queue_req(-8388608, 0, 0);
        for (int i = 0; i < 10; i++)
            queue_req((i % 2) ? -8388608 : 8388607, 0, 0);
        queue_req(1, 0, 0);
        queue_req(-1, 0, 0);
        queue_req(8388607, 1, 1);
        queue_req(-8388608, 0, 0);
        queue_req(0, 1, 0);
        queue_req(0, 0, 0);
        queue_req(12, 1, 0);
        for (int i = 0; i < 1330; i++)
            queue_req(random_sample(), $urandom_range(0, 199) == 0,
                      (i % 400) == 200);

        while (pending_reqs.size() > QuietTail)
            @(posedge clk);
        quiet = 1;
        while (pending_reqs.size() > 0 || in_req.valid || expected_loudness.size() > 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);
        if (error_count == 0)
            $display("k_weighted_loudness_meter_tb: clean");
        else
            $display("k_weighted_loudness_meter_tb: errors");
        $finish;
    end

    initial
    begin
        #400ms;
        $display("k_weighted_loudness_meter_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/kwlm_pkg.sv
hw/rtl/kwlm_if.sv
hw/rtl/kwlm_mac.sv
hw/rtl/kwlm_div.sv
hw/rtl/k_weighted_loudness_meter.sv
bench/kwlm_loudness_tb_types.sv
bench/k_weighted_loudness_meter_tb.sv
